### sv/track_displacement_to_line_unit_assert.svh
// Assertion macros for the track displacement unit.
// They expect aclk and aresetn in scope.
`ifndef TRACK_DISPLACEMENT_TO_LINE_UNIT_ASSERT_SVH
`define TRACK_DISPLACEMENT_TO_LINE_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define TDL_ASSERT_IMM(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("%m: check failed");
// next-cycle implication
`define TDL_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("%m: check failed");
`else
`define TDL_ASSERT_IMM(label, ante, cons)
`define TDL_ASSERT_NXT(label, ante, cons)
`endif

`endif

### sv/tdl_pkg.sv
`default_nettype none

package tdl_pkg;

    // configuration register indexes
    localparam int CFG_INDEX_BITS = 3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ENTRY_X = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ENTRY_Y = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ENTRY_Z = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_EXIT_X  = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_EXIT_Y  = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_EXIT_Z  = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ALGO    = 3'd6;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SIGN    = 3'd7;

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DOT_LOAD,
        ST_DOT_RUN,
        ST_DOT_NEXT,
        ST_DEN_ABS,
        ST_SCL_LOAD,
        ST_SCL_RUN,
        ST_DIV_ABS,
        ST_DIV_PREP,
        ST_DIV_RUN,
        ST_DISP,
        ST_EMIT_CALC,
        ST_EMIT_END,
        ST_FINISH
    } tdl_state_t;

endpackage

`default_nettype wire

### sv/track_displacement_to_line_unit.sv
// Displacement of 3-D track samples from the line between a configured entry and exit
// point. One sample word is taken at a time; s_tready is low while it is worked on. The
// multiplies, divisions and absolute values go through one shared adder path: a shift-add
// multiplier (one multiplier bit per cycle) and a restoring divider (one quotient bit per
// cycle). A sample that needs the projection runs six dot-product multiplies, then per
// coordinate one scale multiply and a division that yields COORD_BITS+4 quotient bits. A
// zero denominator skips the scale multiplies and divisions. In derivative mode a sample
// that owes no inner result goes from IDLE through EMIT_END and FINISH, waiting only for
// the output register. A result waits in the output register while the next sample is
// taken; derivative mode may give two result words for one sample (the owed inner one
// first), and results lag one sample there.

`default_nettype none

`include "track_displacement_to_line_unit_assert.svh"

module track_displacement_to_line_unit #(
    parameter int COORD_BITS = 32,
    parameter int INDEX_BITS = 16
) (
    input  wire logic                                        aclk,
    input  wire logic                                        aresetn,
    // configuration write port
    input  wire logic                                        cfg_wen,
    input  wire logic [tdl_pkg::CFG_INDEX_BITS-1:0]          cfg_index,
    input  wire logic [COORD_BITS-1:0]                       cfg_wdata,
    // sample stream
    input  wire logic                                        s_tvalid,
    output logic                                             s_tready,
    // fields from bit 0: sample_x, sample_y, sample_z
    input  wire logic [((3*COORD_BITS+7)/8)*8-1:0]           s_tdata,
    input  wire logic                                        s_tlast,
    // result stream
    output logic                                             m_tvalid,
    input  wire logic                                        m_tready,
    // fields from bit 0: sample_index, disp_x, disp_y, disp_z
    output logic [((INDEX_BITS+3*COORD_BITS+7)/8)*8-1:0]     m_tdata,
    // fields from bit 0: degenerate
    output logic                                             m_tuser,
    output logic                                             m_tlast
);

    localparam int CB    = COORD_BITS;
    localparam int W     = 3*CB + 8;          // accumulator / remainder width
    localparam int QW    = CB + 3;            // quotient bits kept before clamping
    localparam int DW    = CB + 6;            // displacement working width
    localparam int CNT_W = $clog2(QW + 1);
    localparam int MDW   = ((INDEX_BITS+3*CB+7)/8)*8;

    // saturate to the coordinate width
    function automatic logic signed [CB-1:0] sat_f(input logic signed [DW-1:0] v);
        logic signed [CB-1:0] r;
        if ((&v[DW-1:CB-1]) || !(|v[DW-1:CB-1])) begin
            r = v[CB-1:0];
        end else if (v[DW-1]) begin
            r = {1'b1, {(CB-1){1'b0}}};
        end else begin
            r = {1'b0, {(CB-1){1'b1}}};
        end
        return r;
    endfunction

    // configuration
    logic signed [CB-1:0] entry_reg [3];
    logic signed [CB-1:0] exit_reg [3];
    logic                 algo_reg;
    logic                 sign_reg;

    // track state
    logic signed [CB-1:0]   s_reg [3], s_next [3];
    logic signed [CB-1:0]   prev_reg [3], prev_next [3];
    logic signed [CB-1:0]   pend_reg [3], pend_next [3];
    logic                   pend_valid_reg, pend_valid_next;
    logic [INDEX_BITS-1:0]  count_reg, count_next;
    logic [INDEX_BITS-1:0]  idx_reg, idx_next;
    logic                   last_reg, last_next;
    logic                   closest_reg, closest_next;

    // sequencer and shared unit
    tdl_pkg::tdl_state_t    state_reg, state_next;
    logic [2:0]             j_reg, j_next;
    logic [1:0]             k_reg, k_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [W-1:0]           acc_reg, acc_next;
    logic [W-1:0]           mc_reg, mc_next;
    logic [CB:0]            mp_reg, mp_next;
    logic                   msub_reg, msub_next;
    logic [W-1:0]           num_reg, num_next;
    logic [W-1:0]           den_reg, den_next;
    logic [W-1:0]           den_mag_reg, den_mag_next;
    logic [QW:0]            q_reg, q_next;
    logic                   neg_reg, neg_next;
    logic signed [CB-1:0]   disp_reg [3], disp_next [3];

    // output register
    logic                   m_valid_reg, m_valid_next;
    logic [INDEX_BITS-1:0]  m_idx_reg, m_idx_next;
    logic signed [CB-1:0]   m_disp_reg [3], m_disp_next [3];
    logic                   m_degen_reg, m_degen_next;
    logic                   m_last_reg, m_last_next;

    // combinational helpers
    logic signed [CB:0]     t_vec [3];
    logic signed [CB:0]     d_cl [3];
    logic signed [CB:0]     d_vec [3];
    logic signed [CB:0]     c_vec [3];
    logic signed [CB:0]     sx_vec [3];
    logic [1:0]             jk;
    logic signed [CB:0]     op_a, op_b;
    logic [CB:0]            op_b_mag;
    logic [CB:0]            t_mag;
    logic [W-1:0]           add_a, add_b;
    logic                   add_sub;
    logic [W:0]             add_sum;
    logic [QW:0]            p_mag;
    logic signed [DW-1:0]   p_val, d_ext, disp_raw;
    logic                   den_zero;
    logic                   out_free;

    // difference vectors
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            t_vec[i]  = {exit_reg[i][CB-1], exit_reg[i]} - {entry_reg[i][CB-1], entry_reg[i]};
            d_cl[i]   = {s_reg[i][CB-1], s_reg[i]} - {entry_reg[i][CB-1], entry_reg[i]};
            c_vec[i]  = {prev_reg[i][CB-1], prev_reg[i]} - {s_reg[i][CB-1], s_reg[i]};
            sx_vec[i] = {s_reg[i][CB-1], s_reg[i]} - {exit_reg[i][CB-1], exit_reg[i]};
            d_vec[i]  = closest_reg ? d_cl[i]
                      : ({pend_reg[i][CB-1], pend_reg[i]} - {entry_reg[i][CB-1], entry_reg[i]});
        end
    end

    // dot-product operand selection: numerator terms first, then denominator terms
    always_comb begin
        jk = (j_reg >= 3'd3) ? 2'(j_reg - 3'd3) : j_reg[1:0];
        if (j_reg < 3'd3) begin
            op_a = closest_reg ? d_vec[jk] : c_vec[jk];
            op_b = closest_reg ? t_vec[jk] : d_vec[jk];
        end else begin
            op_a = closest_reg ? t_vec[jk] : c_vec[jk];
            op_b = t_vec[jk];
        end
        op_b_mag = op_b[CB] ? (CB+1)'(-op_b) : op_b;
        t_mag    = t_vec[k_reg][CB] ? (CB+1)'(-t_vec[k_reg]) : t_vec[k_reg];
    end

    // displacement from the rounded quotient, clamped where it overflows
    always_comb begin
        p_mag    = q_reg[QW] ? ((QW+1)'(1) << QW) : q_reg;
        p_val    = neg_reg ? -DW'(p_mag) : DW'(p_mag);
        d_ext    = DW'(d_vec[k_reg]);
        disp_raw = (closest_reg && sign_reg) ? (p_val - d_ext) : (d_ext - p_val);
    end

    assign den_zero = (den_reg == '0);
    assign out_free = !m_valid_reg || m_tready;
    assign add_sum  = {1'b0, add_a} + {1'b0, (add_sub ? ~add_b : add_b)} + (W+1)'(add_sub);

    // sequencer: next state, shared adder control and datapath updates
    always_comb begin
        state_next      = state_reg;
        j_next          = j_reg;
        k_next          = k_reg;
        cnt_next        = cnt_reg;
        acc_next        = acc_reg;
        mc_next         = mc_reg;
        mp_next         = mp_reg;
        msub_next       = msub_reg;
        num_next        = num_reg;
        den_next        = den_reg;
        den_mag_next    = den_mag_reg;
        q_next          = q_reg;
        neg_next        = neg_reg;
        pend_valid_next = pend_valid_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        last_next       = last_reg;
        closest_next    = closest_reg;
        for (int i = 0; i < 3; i++) begin
            s_next[i]      = s_reg[i];
            prev_next[i]   = prev_reg[i];
            pend_next[i]   = pend_reg[i];
            disp_next[i]   = disp_reg[i];
            m_disp_next[i] = m_disp_reg[i];
        end
        m_valid_next = m_valid_reg && !m_tready;
        m_idx_next   = m_idx_reg;
        m_degen_next = m_degen_reg;
        m_last_next  = m_last_reg;
        add_a        = acc_reg;
        add_b        = mc_reg;
        add_sub      = msub_reg;
        s_tready     = 1'b0;

        case (state_reg)
            tdl_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    for (int i = 0; i < 3; i++) begin
                        s_next[i] = s_tdata[i*CB +: CB];
                    end
                    last_next    = s_tlast;
                    idx_next     = count_reg;
                    closest_next = algo_reg;
                    j_next       = 3'd0;
                    if (algo_reg || pend_valid_reg) begin
                        state_next = tdl_pkg::ST_DOT_LOAD;
                    end else begin
                        state_next = tdl_pkg::ST_EMIT_END;
                    end
                end
            end

            tdl_pkg::ST_DOT_LOAD: begin
                mc_next   = W'(op_a);
                mp_next   = op_b_mag;
                msub_next = op_b[CB];
                cnt_next  = CNT_W'(CB);
                if (j_reg == 3'd0 || j_reg == 3'd3) begin
                    acc_next = '0;
                end
                state_next = tdl_pkg::ST_DOT_RUN;
            end

            // shift-add multiply step, shared by dot products and scaling
            tdl_pkg::ST_DOT_RUN, tdl_pkg::ST_SCL_RUN: begin
                if (mp_reg[0]) begin
                    acc_next = add_sum[W-1:0];
                end
                mc_next  = mc_reg << 1;
                mp_next  = mp_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = (state_reg == tdl_pkg::ST_DOT_RUN) ? tdl_pkg::ST_DOT_NEXT
                                                                    : tdl_pkg::ST_DIV_ABS;
                end
            end

            tdl_pkg::ST_DOT_NEXT: begin
                if (j_reg == 3'd2) begin
                    num_next = acc_reg;
                end
                if (j_reg == 3'd5) begin
                    den_next   = acc_reg;
                    state_next = tdl_pkg::ST_DEN_ABS;
                end else begin
                    j_next     = j_reg + 3'd1;
                    state_next = tdl_pkg::ST_DOT_LOAD;
                end
            end

            tdl_pkg::ST_DEN_ABS: begin
                add_a        = '0;
                add_b        = den_reg;
                add_sub      = 1'b1;
                den_mag_next = den_reg[W-1] ? add_sum[W-1:0] : den_reg;
                k_next       = 2'd0;
                state_next   = tdl_pkg::ST_SCL_LOAD;
            end

            tdl_pkg::ST_SCL_LOAD: begin
                if (den_zero) begin
                    q_next     = '0;
                    neg_next   = 1'b0;
                    state_next = tdl_pkg::ST_DISP;
                end else begin
                    mc_next    = num_reg;
                    mp_next    = t_mag;
                    msub_next  = t_vec[k_reg][CB];
                    acc_next   = '0;
                    cnt_next   = CNT_W'(CB);
                    state_next = tdl_pkg::ST_SCL_RUN;
                end
            end

            // magnitude of the product and sign of the quotient
            tdl_pkg::ST_DIV_ABS: begin
                add_a      = '0;
                add_b      = acc_reg;
                add_sub    = 1'b1;
                neg_next   = acc_reg[W-1] ^ den_reg[W-1];
                acc_next   = acc_reg[W-1] ? add_sum[W-1:0] : acc_reg;
                state_next = tdl_pkg::ST_DIV_PREP;
            end

            // round to nearest: (2a + b) / (2b)
            tdl_pkg::ST_DIV_PREP: begin
                add_a      = acc_reg << 1;
                add_b      = den_mag_reg;
                add_sub    = 1'b0;
                acc_next   = add_sum[W-1:0];
                mc_next    = den_mag_reg << (QW + 1);
                q_next     = '0;
                cnt_next   = CNT_W'(QW);
                state_next = tdl_pkg::ST_DIV_RUN;
            end

            // restoring division, one quotient bit per cycle
            tdl_pkg::ST_DIV_RUN: begin
                add_a   = acc_reg;
                add_b   = mc_reg;
                add_sub = 1'b1;
                if (add_sum[W]) begin
                    acc_next = add_sum[W-1:0];
                end
                q_next   = {q_reg[QW-1:0], add_sum[W]};
                mc_next  = mc_reg >> 1;
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    state_next = tdl_pkg::ST_DISP;
                end
            end

            tdl_pkg::ST_DISP: begin
                disp_next[k_reg] = sat_f(disp_raw);
                if (k_reg == 2'd2) begin
                    state_next = tdl_pkg::ST_EMIT_CALC;
                end else begin
                    k_next     = k_reg + 2'd1;
                    state_next = tdl_pkg::ST_SCL_LOAD;
                end
            end

            tdl_pkg::ST_EMIT_CALC: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_idx_next   = closest_reg ? idx_reg : (idx_reg - INDEX_BITS'(1));
                    for (int i = 0; i < 3; i++) begin
                        m_disp_next[i] = disp_reg[i];
                    end
                    m_degen_next = den_zero;
                    m_last_next  = closest_reg && last_reg;
                    state_next   = closest_reg ? tdl_pkg::ST_FINISH : tdl_pkg::ST_EMIT_END;
                end
            end

            // derivative mode: first sample against entry, last against exit
            tdl_pkg::ST_EMIT_END: begin
                if (idx_reg == '0 || last_reg) begin
                    if (out_free) begin
                        m_valid_next = 1'b1;
                        m_idx_next   = idx_reg;
                        for (int i = 0; i < 3; i++) begin
                            if (idx_reg == '0) begin
                                m_disp_next[i] = last_reg ? '0 : sat_f(DW'(d_cl[i]));
                            end else begin
                                m_disp_next[i] = sat_f(DW'(sx_vec[i]));
                            end
                        end
                        m_degen_next = 1'b0;
                        m_last_next  = last_reg;
                        state_next   = tdl_pkg::ST_FINISH;
                    end
                end else begin
                    state_next = tdl_pkg::ST_FINISH;
                end
            end

            tdl_pkg::ST_FINISH: begin
                for (int i = 0; i < 3; i++) begin
                    prev_next[i] = pend_reg[i];
                    pend_next[i] = s_reg[i];
                end
                count_next      = last_reg ? '0 : (idx_reg + INDEX_BITS'(1));
                pend_valid_next = !closest_reg && (idx_reg != '0) && !last_reg;
                state_next      = tdl_pkg::ST_IDLE;
            end

            default: begin
                state_next = tdl_pkg::ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= tdl_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_valid_reg <= 1'b0;
            count_reg      <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            pend_valid_reg <= pend_valid_next;
            count_reg      <= count_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge aclk) begin
        j_reg       <= j_next;
        k_reg       <= k_next;
        cnt_reg     <= cnt_next;
        acc_reg     <= acc_next;
        mc_reg      <= mc_next;
        mp_reg      <= mp_next;
        msub_reg    <= msub_next;
        num_reg     <= num_next;
        den_reg     <= den_next;
        den_mag_reg <= den_mag_next;
        q_reg       <= q_next;
        neg_reg     <= neg_next;
        idx_reg     <= idx_next;
        last_reg    <= last_next;
        closest_reg <= closest_next;
        m_idx_reg   <= m_idx_next;
        m_degen_reg <= m_degen_next;
        m_last_reg  <= m_last_next;
        for (int i = 0; i < 3; i++) begin
            s_reg[i]      <= s_next[i];
            prev_reg[i]   <= prev_next[i];
            pend_reg[i]   <= pend_next[i];
            disp_reg[i]   <= disp_next[i];
            m_disp_reg[i] <= m_disp_next[i];
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 3; i++) begin
                entry_reg[i] <= '0;
                exit_reg[i]  <= '0;
            end
            algo_reg <= 1'b1;
            sign_reg <= 1'b1;
        end else if (cfg_wen) begin
            case (cfg_index)
                tdl_pkg::REG_ENTRY_X: entry_reg[0] <= cfg_wdata;
                tdl_pkg::REG_ENTRY_Y: entry_reg[1] <= cfg_wdata;
                tdl_pkg::REG_ENTRY_Z: entry_reg[2] <= cfg_wdata;
                tdl_pkg::REG_EXIT_X:  exit_reg[0]  <= cfg_wdata;
                tdl_pkg::REG_EXIT_Y:  exit_reg[1]  <= cfg_wdata;
                tdl_pkg::REG_EXIT_Z:  exit_reg[2]  <= cfg_wdata;
                tdl_pkg::REG_ALGO:    algo_reg     <= cfg_wdata[0];
                tdl_pkg::REG_SIGN:    sign_reg     <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    // result port
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = MDW'({m_disp_reg[2], m_disp_reg[1], m_disp_reg[0], m_idx_reg});
    assign m_tuser  = m_degen_reg;
    assign m_tlast  = m_last_reg;

    // checks
    `TDL_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    `TDL_ASSERT_IMM(a_div_nonzero_den, state_reg == tdl_pkg::ST_DIV_RUN, den_reg != '0)
    `TDL_ASSERT_NXT(a_count_clears_on_last, (state_reg == tdl_pkg::ST_FINISH) && last_reg, count_reg == '0)

endmodule

`default_nettype wire
